// ===== rtl/cltm_pkg.sv =====
// ----------------------------------------------------------------------------
// Caching lock table manager package
// Shared types and codes for the lock table controller, datapath and channels.
// ----------------------------------------------------------------------------
`default_nettype none

package cltm_pkg;

    localparam int LOCK_ID_W   = 8;
    localparam int CLIENT_ID_W = 4;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic {
        GR_OK    = 1'b0,
        GR_RETRY = 1'b1
    } grant_t;

    // per-lock phase; the fourth code never arises and is treated as free
    typedef enum logic [1:0] {
        PH_FREE   = 2'd0,
        PH_LOCKED = 2'd1,
        PH_WAIT   = 2'd2
    } phase_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/cltm_if.sv =====
// ----------------------------------------------------------------------------
// Caching lock table manager channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cltm_req_if import cltm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [LOCK_ID_W-1:0]   lock_id;
    logic [CLIENT_ID_W-1:0] client_id;

    modport source (output valid, opcode, lock_id, client_id, input ready);
    modport sink   (input valid, opcode, lock_id, client_id, output ready);
endinterface

interface cltm_rsp_if import cltm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   grant_status;
    logic                   revoke_valid;
    logic [CLIENT_ID_W-1:0] revoke_client;
    logic                   retry_valid;
    logic [CLIENT_ID_W-1:0] retry_client;
    logic                   release_error;

    modport source (output valid, grant_status, revoke_valid, revoke_client,
                    retry_valid, retry_client, release_error, input ready);
    modport sink   (input valid, grant_status, revoke_valid, revoke_client,
                    retry_valid, retry_client, release_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/cltm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lock table controller
// Sequences one request: accept and table read, then update and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module cltm_ctrl import cltm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // hold until the result register can take the outcome
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_CALC:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    a_capture_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_CALC)
        else $error("capture not followed by update state");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC && !sts.out_free) |=> state_reg == ST_CALC)
        else $error("update left while result register full");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit together");

endmodule

`default_nettype wire

// ===== rtl/cltm_dpath.sv =====
// ----------------------------------------------------------------------------
// Lock table datapath
// Lock table memory, entry valid flags, update logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cltm_dpath import cltm_pkg::*;
#(
    parameter int unsigned LOCKS   = 256,
    parameter int unsigned CLIENTS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output sts_t                        sts,
    input  wire logic                   req_opcode,
    input  wire logic [LOCK_ID_W-1:0]   req_lock_id,
    input  wire logic [CLIENT_ID_W-1:0] req_client_id,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output logic                        rsp_grant_status,
    output logic                        rsp_revoke_valid,
    output logic [CLIENT_ID_W-1:0]      rsp_revoke_client,
    output logic                        rsp_retry_valid,
    output logic [CLIENT_ID_W-1:0]      rsp_retry_client,
    output logic                        rsp_release_error
);

    localparam int ID_SPAN   = 1 << LOCK_ID_W;
    localparam int CID_SPAN  = 1 << CLIENT_ID_W;
    localparam int DEPTH     = (LOCKS < ID_SPAN) ? LOCKS : ID_SPAN;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // modulo tables, folded to constants at elaboration
    logic [AW-1:0]          lock_tab [ID_SPAN];
    logic [CLIENT_ID_W-1:0] cid_tab  [CID_SPAN];

    for (genvar i = 0; i < ID_SPAN; i++)
    begin : g_lock_tab
        assign lock_tab[i] = AW'(i % LOCKS);
    end

    for (genvar j = 0; j < CID_SPAN; j++)
    begin : g_cid_tab
        assign cid_tab[j] = CLIENT_ID_W'(j % CLIENTS);
    end

    // table storage
    phase_t                 phase_mem  [DEPTH];
    logic [CLIENT_ID_W-1:0] holder_mem [DEPTH];
    logic [CLIENT_ID_W-1:0] next_mem   [DEPTH];
    logic [CLIENTS-1:0]     mask_mem   [DEPTH];
    logic [DEPTH-1:0]       entry_vld_reg;

    // captured request and read data
    op_t                    op_reg;
    logic [AW-1:0]          idx_reg;
    logic [CLIENT_ID_W-1:0] cid_reg;
    logic                   rd_vld_reg;
    phase_t                 rd_phase_reg;
    logic [CLIENT_ID_W-1:0] rd_holder_reg;
    logic [CLIENT_ID_W-1:0] rd_next_reg;
    logic [CLIENTS-1:0]     rd_mask_reg;

    logic                   rsp_valid_reg;
    grant_t                 rsp_grant_reg;
    logic                   rsp_revoke_valid_reg;
    logic [CLIENT_ID_W-1:0] rsp_revoke_client_reg;
    logic                   rsp_retry_valid_reg;
    logic [CLIENT_ID_W-1:0] rsp_retry_client_reg;
    logic                   rsp_release_error_reg;

    logic [AW-1:0]          rd_idx;

    assign rd_idx = lock_tab[req_lock_id];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= op_t'(req_opcode);
            idx_reg       <= rd_idx;
            cid_reg       <= cid_tab[req_client_id];
            rd_phase_reg  <= phase_mem[rd_idx];
            rd_holder_reg <= holder_mem[rd_idx];
            rd_next_reg   <= next_mem[rd_idx];
            rd_mask_reg   <= mask_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            entry_vld_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rd_vld_reg <= entry_vld_reg[rd_idx];
            end
            if (cmd.commit)
            begin
                entry_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // an entry never written reads as the cleared state
    phase_t                 cur_phase;
    logic [CLIENT_ID_W-1:0] cur_holder;
    logic [CLIENT_ID_W-1:0] cur_next;
    logic [CLIENTS-1:0]     cur_mask;

    assign cur_phase  = rd_vld_reg ? rd_phase_reg  : PH_FREE;
    assign cur_holder = rd_vld_reg ? rd_holder_reg : '0;
    assign cur_next   = rd_vld_reg ? rd_next_reg   : '0;
    assign cur_mask   = rd_vld_reg ? rd_mask_reg   : '0;

    function automatic logic [CLIENT_ID_W-1:0] lowest_waiter(input logic [CLIENTS-1:0] m);
        logic [CLIENT_ID_W-1:0] r;
        r = '0;
        for (int c = CLIENTS - 1; c >= 0; c--)
        begin
            if (m[c])
            begin
                r = CLIENT_ID_W'(c);
            end
        end
        return r;
    endfunction

    logic [CLIENTS-1:0]     cbit;
    logic [CLIENTS-1:0]     mask_shift;
    logic [CLIENTS-1:0]     mask_left;
    logic                   nx_waiting;

    assign cbit       = CLIENTS'(1) << cid_reg;
    assign mask_shift = cur_mask >> cur_next;
    assign nx_waiting = mask_shift[0];
    assign mask_left  = cur_mask & ~cbit;

    phase_t                 new_phase;
    logic [CLIENT_ID_W-1:0] new_holder;
    logic [CLIENT_ID_W-1:0] new_next;
    logic [CLIENTS-1:0]     new_mask;
    grant_t                 res_grant;
    logic                   res_rv;
    logic [CLIENT_ID_W-1:0] res_rvc;
    logic                   res_rt;
    logic [CLIENT_ID_W-1:0] res_rtc;
    logic                   res_rerr;

    always_comb
    begin
        new_phase  = cur_phase;
        new_holder = cur_holder;
        new_next   = cur_next;
        new_mask   = cur_mask;
        res_grant  = GR_OK;
        res_rv     = 1'b0;
        res_rvc    = '0;
        res_rt     = 1'b0;
        res_rtc    = '0;
        res_rerr   = 1'b0;
        case (op_reg)
            OP_ACQUIRE:
            begin
                case (cur_phase)
                    PH_LOCKED:
                    begin
                        // queue requester and ask the holder to give it back
                        new_phase = PH_WAIT;
                        new_mask  = cur_mask | cbit;
                        new_next  = cid_reg;
                        res_grant = GR_RETRY;
                        res_rv    = 1'b1;
                        res_rvc   = cur_holder;
                    end
                    PH_WAIT:
                    begin
                        if (nx_waiting && (cur_next == cid_reg))
                        begin
                            new_holder = cur_next;
                            new_mask   = mask_left;
                            if (mask_left == '0)
                            begin
                                new_phase = PH_LOCKED;
                                new_next  = '0;
                            end
                            else
                            begin
                                new_next = lowest_waiter(mask_left);
                                res_rv   = 1'b1;
                                res_rvc  = cur_next;
                            end
                        end
                        else
                        begin
                            new_mask  = cur_mask | cbit;
                            res_grant = GR_RETRY;
                        end
                    end
                    default:
                    begin
                        new_phase  = PH_LOCKED;
                        new_holder = cid_reg;
                    end
                endcase
            end
            OP_RELEASE:
            begin
                case (cur_phase)
                    PH_LOCKED:
                    begin
                        new_phase  = PH_FREE;
                        new_holder = '0;
                    end
                    PH_WAIT:
                    begin
                        new_holder = '0;
                        res_rt     = 1'b1;
                        res_rtc    = cur_next;
                    end
                    default:
                    begin
                        res_rerr = 1'b1;
                    end
                endcase
            end
            default:
            begin
                res_rerr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            phase_mem[idx_reg]  <= new_phase;
            holder_mem[idx_reg] <= new_holder;
            next_mem[idx_reg]   <= new_next;
            mask_mem[idx_reg]   <= new_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_grant_reg         <= res_grant;
            rsp_revoke_valid_reg  <= res_rv;
            rsp_revoke_client_reg <= res_rvc;
            rsp_retry_valid_reg   <= res_rt;
            rsp_retry_client_reg  <= res_rtc;
            rsp_release_error_reg <= res_rerr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free       = !rsp_valid_reg || rsp_ready;
    assign rsp_valid          = rsp_valid_reg;
    assign rsp_grant_status   = rsp_grant_reg;
    assign rsp_revoke_valid   = rsp_revoke_valid_reg;
    assign rsp_revoke_client  = rsp_revoke_client_reg;
    assign rsp_retry_valid    = rsp_retry_valid_reg;
    assign rsp_retry_client   = rsp_retry_client_reg;
    assign rsp_release_error  = rsp_release_error_reg;

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result overwritten before transfer");

    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid_reg && entry_vld_reg[$past(idx_reg)])
        else $error("commit did not load result or mark entry");

    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == OP_RELEASE)
        |=> rsp_grant_reg == GR_OK && !rsp_revoke_valid_reg)
        else $error("release produced a retry grant or revoke");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_rerr) |-> (!res_rv && !res_rt && op_reg == OP_RELEASE))
        else $error("release error mixed with messages");

endmodule

`default_nettype wire

// ===== rtl/caching_lock_table_manager.sv =====
// ----------------------------------------------------------------------------
// Caching lock table manager
// Lock table with revoke and retry messaging, one result per request.
//
//   channel | role   | handshake   | payload
//   req     | sink   | valid/ready | opcode, lock_id, client_id
//   rsp     | source | valid/ready | grant_status, revoke_valid/client,
//           |        |             | retry_valid/client, release_error
//
// A request is handled in order: accept with table read, then update, table
// write and result load. The registered table read port sets this split.
// One request is in flight at a time; the next may be accepted while the
// previous result still waits for transfer on rsp.
// Reset clears per-entry valid flags at once; no clearing pass is needed.
// A stalled rsp holds the update step until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module caching_lock_table_manager import cltm_pkg::*;
#(
    parameter int unsigned LOCKS   = 256,
    parameter int unsigned CLIENTS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cltm_req_if.sink    req,
    cltm_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;

    cltm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cltm_dpath #(
        .LOCKS   (LOCKS),
        .CLIENTS (CLIENTS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_opcode        (req.opcode),
        .req_lock_id       (req.lock_id),
        .req_client_id     (req.client_id),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_grant_status  (rsp.grant_status),
        .rsp_revoke_valid  (rsp.revoke_valid),
        .rsp_revoke_client (rsp.revoke_client),
        .rsp_retry_valid   (rsp.retry_valid),
        .rsp_retry_client  (rsp.retry_client),
        .rsp_release_error (rsp.release_error)
    );

endmodule

`default_nettype wire

// ===== tb/sv/cltm_lock_checker.sv =====
// ----------------------------------------------------------------------------
// Lock table reply checker
// Watches the request and reply channels and keeps a shadow of the lock table.
// On every accepted request it works out the expected reply from the shadow.
// Each reply transfer is compared with the oldest expected reply. The checker
// hands the failure count and the number of outstanding replies to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cltm_lock_checker import cltm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cltm_req_if       req,
    cltm_rsp_if       rsp,
    output int        fail_count,
    output int        pending
);

    localparam int LOCK_COUNT   = 1 << LOCK_ID_W;
    localparam int CLIENT_COUNT = 1 << CLIENT_ID_W;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        grant_t                 grant_status;
        logic                   revoke_valid;
        logic [CLIENT_ID_W-1:0] revoke_client;
        logic                   retry_valid;
        logic [CLIENT_ID_W-1:0] retry_client;
        logic                   release_error;
    } lock_reply_t;

    phase_t                  phase_tbl  [LOCK_COUNT];
    logic [CLIENT_ID_W-1:0]  holder_tbl [LOCK_COUNT];
    logic [CLIENT_ID_W-1:0]  next_tbl   [LOCK_COUNT];
    logic [CLIENT_COUNT-1:0] waiter_tbl [LOCK_COUNT];
    lock_reply_t             reply_q    [$];
    int                      mismatches;

    function automatic logic [CLIENT_ID_W-1:0] lowest_waiter(
        input logic [CLIENT_COUNT-1:0] mask
    );
        for (int c = 0; c < CLIENT_COUNT; c++)
            if (mask[c])
                return CLIENT_ID_W'(c);
        return '0;
    endfunction

    // update the shadow table for one request and return the reply it causes
    function automatic lock_reply_t apply_lock_request(
        input op_t                    op,
        input logic [LOCK_ID_W-1:0]   lk,
        input logic [CLIENT_ID_W-1:0] cl
    );
        lock_reply_t             r;
        logic [CLIENT_COUNT-1:0] cbit;
        logic [CLIENT_ID_W-1:0]  nx;
        r    = '0;
        cbit = {{(CLIENT_COUNT-1){1'b0}}, 1'b1} << cl;
        if (op == OP_ACQUIRE)
        begin
            case (phase_tbl[lk])
                PH_LOCKED:
                begin
                    phase_tbl[lk]   = PH_WAIT;
                    waiter_tbl[lk] |= cbit;
                    next_tbl[lk]    = cl;
                    r.grant_status  = GR_RETRY;
                    r.revoke_valid  = 1'b1;
                    r.revoke_client = holder_tbl[lk];
                end
                PH_WAIT:
                begin
                    nx = next_tbl[lk];
                    if (waiter_tbl[lk][nx] && nx == cl)
                    begin
                        holder_tbl[lk]  = cl;
                        waiter_tbl[lk] &= ~cbit;
                        if (waiter_tbl[lk] == '0)
                        begin
                            phase_tbl[lk] = PH_LOCKED;
                            next_tbl[lk]  = '0;
                        end
                        else
                        begin
                            next_tbl[lk]    = lowest_waiter(waiter_tbl[lk]);
                            r.revoke_valid  = 1'b1;
                            r.revoke_client = holder_tbl[lk];
                        end
                        r.grant_status = GR_OK;
                    end
                    else
                    begin
                        waiter_tbl[lk] |= cbit;
                        r.grant_status  = GR_RETRY;
                    end
                end
                // free, and the unused code that counts as free
                default:
                begin
                    phase_tbl[lk]  = PH_LOCKED;
                    holder_tbl[lk] = cl;
                end
            endcase
        end
        else
        begin
            case (phase_tbl[lk])
                PH_LOCKED:
                begin
                    phase_tbl[lk]  = PH_FREE;
                    holder_tbl[lk] = '0;
                end
                PH_WAIT:
                begin
                    holder_tbl[lk] = '0;
                    r.retry_valid  = 1'b1;
                    r.retry_client = next_tbl[lk];
                end
                default:
                    r.release_error = 1'b1;
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lock_reply_t exp_r;
        lock_reply_t got_r;
        if (!rst_n)
        begin
            for (int i = 0; i < LOCK_COUNT; i++)
            begin
                phase_tbl[i]  = PH_FREE;
                holder_tbl[i] = '0;
                next_tbl[i]   = '0;
                waiter_tbl[i] = '0;
            end
            reply_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                reply_q.push_back(apply_lock_request(op_t'(req.opcode), req.lock_id,
                                                     req.client_id));
            if (rsp.valid && rsp.ready)
            begin
                got_r.grant_status  = grant_t'(rsp.grant_status);
                got_r.revoke_valid  = rsp.revoke_valid;
                got_r.revoke_client = rsp.revoke_client;
                got_r.retry_valid   = rsp.retry_valid;
                got_r.retry_client  = rsp.retry_client;
                got_r.release_error = rsp.release_error;
                if (reply_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("reply transfer with no request outstanding: grant=%0b",
                                 got_r.grant_status,
                                 " revoke=%0b/%0d retry=%0b/%0d rel_err=%0b",
                                 got_r.revoke_valid, got_r.revoke_client,
                                 got_r.retry_valid, got_r.retry_client,
                                 got_r.release_error);
                end
                else
                begin
                    exp_r = reply_q.pop_front();
                    if (got_r !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("reply mismatch at %0t", $realtime);
                            $display("  expected grant=%0b revoke=%0b/%0d retry=%0b/%0d",
                                     exp_r.grant_status, exp_r.revoke_valid,
                                     exp_r.revoke_client, exp_r.retry_valid,
                                     exp_r.retry_client, " rel_err=%0b",
                                     exp_r.release_error);
                            $display("  actual   grant=%0b revoke=%0b/%0d retry=%0b/%0d",
                                     got_r.grant_status, got_r.revoke_valid,
                                     got_r.revoke_client, got_r.retry_valid,
                                     got_r.retry_client, " rel_err=%0b",
                                     got_r.release_error);
                        end
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= reply_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Lock table manager testbench
// Drives lock requests into the block and takes its replies, with random idle
// cycles on both sides. A directed run covers the lock transitions first. A
// random run then works small pools of locks and clients so that locks pass
// through contention, revoke and retry. The checker does the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import cltm_pkg::*;
();

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_ITEMS     = 1930;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int POOL_ITEMS       = 150;
    localparam int SETTLE_CYCLES    = 8;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   hold_requests;
    int   holds_done;
    int   tx_stretch;
    bit   tx_no_gap;
    int   tx_rush;

    cltm_req_if req ();
    cltm_rsp_if rsp ();

    caching_lock_table_manager dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    cltm_lock_checker lock_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // offer one request after a random gap and hold it until the transfer
    task automatic send_request(
        input op_t                    op,
        input logic [LOCK_ID_W-1:0]   lk,
        input logic [CLIENT_ID_W-1:0] cl
    );
        int gap;
        if (tx_stretch == 0)
        begin
            tx_stretch = $urandom_range(80, 10);
            tx_no_gap  = ($urandom_range(3) == 0);
        end
        tx_stretch--;
        gap = (tx_no_gap || tx_rush > 0) ? 0 : $urandom_range(10);
        if (tx_rush > 0)
            tx_rush--;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.opcode    <= op;
        req.lock_id   <= lk;
        req.client_id <= cl;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // drop valid and hold off until every outstanding reply has come back
    task automatic drain_replies();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : reply_sink
        int stall;
        int stretch;
        bit no_stall;
        stretch   = 0;
        no_stall  = 0;
        holds_done = 0;
        rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (stretch == 0)
            begin
                stretch  = $urandom_range(80, 10);
                no_stall = ($urandom_range(3) == 0);
            end
            stretch--;
            stall = no_stall ? 0 : $urandom_range(10);
            // a long hold lets the block fill up and stall its request side
            if (hold_requests != holds_done)
            begin
                stall = LONG_HOLD_CYCLES;
                holds_done++;
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [LOCK_ID_W-1:0]   hot_locks   [4];
        logic [CLIENT_ID_W-1:0] hot_clients [4];
        logic [LOCK_ID_W-1:0]   lk;
        logic [CLIENT_ID_W-1:0] cl;
        op_t                    op;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.opcode    = OP_ACQUIRE;
        req.lock_id   = '0;
        req.client_id = '0;
        hold_requests = 0;
        tx_stretch    = 0;
        tx_no_gap     = 0;
        tx_rush       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // release on a free lock, then a full contention round on lock 0
        send_request(OP_RELEASE, 8'h00, 4'd0);
        send_request(OP_ACQUIRE, 8'h00, 4'd15);
        send_request(OP_ACQUIRE, 8'h00, 4'd3);
        send_request(OP_ACQUIRE, 8'h00, 4'd7);
        send_request(OP_RELEASE, 8'h00, 4'd15);
        send_request(OP_ACQUIRE, 8'h00, 4'd3);
        send_request(OP_ACQUIRE, 8'h00, 4'd7);
        send_request(OP_RELEASE, 8'h00, 4'd9);
        send_request(OP_RELEASE, 8'h00, 4'd7);
        // top lock id: holder re-queues itself behind the next client
        send_request(OP_ACQUIRE, 8'hFF, 4'd0);
        send_request(OP_ACQUIRE, 8'hFF, 4'd15);
        send_request(OP_ACQUIRE, 8'hFF, 4'd0);
        send_request(OP_ACQUIRE, 8'hFF, 4'd15);
        send_request(OP_RELEASE, 8'hFF, 4'd15);
        send_request(OP_ACQUIRE, 8'hFF, 4'd0);
        send_request(OP_RELEASE, 8'hFF, 4'd0);
        send_request(OP_RELEASE, 8'hFF, 4'd0);
        // mid-range ids, acquire by a client that is not next
        send_request(OP_ACQUIRE, 8'h5A, 4'd10);
        send_request(OP_ACQUIRE, 8'h5A, 4'd5);
        send_request(OP_ACQUIRE, 8'h5A, 4'd12);
        send_request(OP_ACQUIRE, 8'hA5, 4'd5);
        send_request(OP_RELEASE, 8'h5A, 4'd10);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // work a fresh small set of locks and clients now and then
            if (i % POOL_ITEMS == 0)
                for (int k = 0; k < 4; k++)
                begin
                    hot_locks[k]   = LOCK_ID_W'($urandom);
                    hot_clients[k] = CLIENT_ID_W'($urandom);
                end
            if (i == 400 || i == 1200)
            begin
                hold_requests <= hold_requests + 1;
                tx_rush = 40;
            end
            if (i == 900 || i == 1600)
                drain_replies();
            lk = ($urandom_range(99) < 85) ? hot_locks[2'($urandom_range(3))]
                                           : LOCK_ID_W'($urandom);
            cl = ($urandom_range(99) < 80) ? hot_clients[2'($urandom_range(3))]
                                           : CLIENT_ID_W'($urandom);
            op = ($urandom_range(99) < 58) ? OP_ACQUIRE : OP_RELEASE;
            send_request(op, lk, cl);
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
